@@ design/ppsch_pkg.sv @@
// shared types and constants for the preemptive priority scheduler
`default_nettype none

package ppsch_pkg;

   // table size unless overridden at the top level
   localparam int DEFAULT_MAX_PROCESSES = 16;

   // fixed field widths
   localparam int TIME_W    = 16;
   localparam int PRIO_W    = 8;
   localparam int TICK_W    = 32;
   localparam int ID_W      = 5;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 104;

   // one table entry as held in the entry memory
   typedef struct packed {
      logic [TIME_W-1:0] remaining;
      logic [PRIO_W-1:0] priority_value;
      logic [TIME_W-1:0] burst_time;
      logic [TIME_W-1:0] arrival_time;
   } entry_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load_en;
      logic tick_start;
      logic scan_issue;
      logic do_update;
      logic do_calc;
      logic do_out;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic table_empty;
      logic scan_last;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

@@ design/preemptive_priority_scheduler.sv @@
// Preemptive priority scheduler, top level.
// Input channel req_*: each transfer is either a table load (req_tuser = 0)
// or a time tick (req_tuser = 1). A load stores arrival, burst and priority
// at the next free table slot as it is accepted; a load into a full table is
// dropped. A tick scans the loaded entries one per cycle through the entry
// memory's read port, picks the arrived, unfinished entry with the smallest
// priority value (lowest id on ties), runs it for one unit and produces one
// result transfer on rsp_*. Load items produce no result.
// A tick passes through the scan state (one memory read per loaded entry),
// then the last, update, calc and out states, where the result is written to
// the output register; on an empty table the scan and last states are skipped.
// The next item is taken in the cycle after the result is registered.
// The result sits in an output register; when the receiver stalls, that
// register holds, and a tick that reaches the out state waits there before
// writing a new result; no input items are taken while it waits.
// Reset is synchronous, active high: it empties the table, clears the done
// flags and completion count and sets the tick counter to zero.
`default_nettype none

module preemptive_priority_scheduler #(
   parameter int MAX_PROCESSES = ppsch_pkg::DEFAULT_MAX_PROCESSES
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // input channel
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // arrival_time[15:0], burst_time[31:16], priority_value[39:32]
   input  wire logic [ppsch_pkg::REQ_DATA_W-1:0] req_tdata,
   // op[0]: 0 load entry, 1 advance tick
   input  wire logic [0:0]                       req_tuser,
   // result channel
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // running_id[4:0], finished[5], finish_time[37:6], turnaround[69:38],
   // waiting[101:70], all_done[102], zero pad[103]
   output logic      [ppsch_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   ppsch_pkg::cmd_type cmd;
   ppsch_pkg::sts_type sts;

   ppsch_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_is_tick (req_tuser[0]),
      .req_tready  (req_tready),
      .sts         (sts),
      .cmd         (cmd)
   );

   ppsch_dp #(
      .MAX_PROCESSES (MAX_PROCESSES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

@@ design/ppsch_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module ppsch_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/ppsch_ctrl.sv @@
// controller state machine: load, scan, update and result sequencing
`default_nettype none

module ppsch_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   input  wire logic              req_is_tick,
   output logic                   req_tready,
   input  wire ppsch_pkg::sts_type sts,
   output ppsch_pkg::cmd_type     cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_LAST   = 3'd2;
   localparam logic [2:0] S_UPDATE = 3'd3;
   localparam logic [2:0] S_CALC   = 3'd4;
   localparam logic [2:0] S_OUT    = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_is_tick) begin
               state_in = sts.table_empty ? S_UPDATE : S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.scan_last) begin
               state_in = S_LAST;
            end
         end
         S_LAST:   state_in = S_UPDATE;
         S_UPDATE: state_in = S_CALC;
         S_CALC:   state_in = S_OUT;
         S_OUT: begin
            if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // command decode
   always_comb begin
      cmd.load_en    = accept && !req_is_tick;
      cmd.tick_start = accept && req_is_tick;
      cmd.scan_issue = (state_ff == S_SCAN);
      cmd.do_update  = (state_ff == S_UPDATE);
      cmd.do_calc    = (state_ff == S_CALC);
      cmd.do_out     = (state_ff == S_OUT) && sts.out_free;
   end

   // a scan is never started on an empty table
   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> !sts.table_empty)
      else $error("scan running on an empty table");

   // the last-entry cycle always follows the last scan read
   a_last_after_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LAST) |-> ($past(state_ff) == S_SCAN))
      else $error("last scan cycle without a preceding scan");

   // a result leaves the output state only when the output register takes it
   a_out_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && !sts.out_free) |=> (state_ff == S_OUT))
      else $error("left output state without a transfer slot");

endmodule

`default_nettype wire

@@ design/ppsch_dp.sv @@
// datapath: entry table, scan selection, tick counter and output register
`default_nettype none

module ppsch_dp #(
   parameter int MAX_PROCESSES = ppsch_pkg::DEFAULT_MAX_PROCESSES
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [ppsch_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire ppsch_pkg::cmd_type              cmd,
   output ppsch_pkg::sts_type                   sts,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [ppsch_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int IDX_W   = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int CNT_W   = $clog2(MAX_PROCESSES + 1);
   localparam int ENTRY_W = $bits(ppsch_pkg::entry_type);
   localparam int TW      = ppsch_pkg::TICK_W;

   // counters and flags
   logic [CNT_W-1:0]         loaded_ff;
   logic [CNT_W-1:0]         completed_ff;
   logic [TW-1:0]            tick_ff;
   logic [MAX_PROCESSES-1:0] done_ff;

   // scan control
   logic [IDX_W-1:0] scan_idx_ff;
   logic             rd_valid_ff;
   logic [IDX_W-1:0] rd_idx_ff;

   // best candidate so far
   logic                          sel_valid_ff;
   logic [IDX_W-1:0]              best_idx_ff;
   logic [ppsch_pkg::PRIO_W-1:0]  best_prio_ff;
   logic [ppsch_pkg::TIME_W-1:0]  best_arr_ff;
   logic [ppsch_pkg::TIME_W-1:0]  best_burst_ff;
   logic [ppsch_pkg::TIME_W-1:0]  best_rem_ff;

   // completion figures
   logic          fin_ff;
   logic [TW-1:0] tat_ff;

   // output register
   logic                           rsp_valid_ff;
   logic [ppsch_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   // memory ports
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   ppsch_pkg::entry_type wr_entry;
   ppsch_pkg::entry_type rd_entry;
   logic [ENTRY_W-1:0]   rd_raw;

   logic       table_full;
   logic       finishing;
   logic       candidate;
   logic [31:0] id_wide;
   logic [ppsch_pkg::ID_W-1:0] running_id;
   logic [TW-1:0] waiting;
   logic          all_done;

   assign table_full = (loaded_ff == CNT_W'(MAX_PROCESSES));
   assign finishing  = sel_valid_ff && (best_rem_ff <= ppsch_pkg::TIME_W'(1));

   // write port: loads at the fill position, updates at the selected entry
   always_comb begin
      wr_entry = '0;
      if (cmd.load_en) begin
         wr_en                   = !table_full;
         wr_addr                 = loaded_ff[IDX_W-1:0];
         wr_entry.arrival_time   = req_tdata[15:0];
         wr_entry.burst_time     = req_tdata[31:16];
         wr_entry.priority_value = req_tdata[39:32];
         wr_entry.remaining      = req_tdata[31:16];
      end else begin
         wr_en                   = cmd.do_update && sel_valid_ff && !finishing;
         wr_addr                 = best_idx_ff;
         wr_entry.arrival_time   = best_arr_ff;
         wr_entry.burst_time     = best_burst_ff;
         wr_entry.priority_value = best_prio_ff;
         wr_entry.remaining      = best_rem_ff - ppsch_pkg::TIME_W'(1);
      end
   end

   ppsch_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_PROCESSES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (cmd.scan_issue),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_raw)
   );

   assign rd_entry = ppsch_pkg::entry_type'(rd_raw);

   // counters, done flags and tick
   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff    <= '0;
         completed_ff <= '0;
         tick_ff      <= '0;
         done_ff      <= '0;
      end else begin
         if (cmd.load_en && !table_full) begin
            loaded_ff                     <= loaded_ff + CNT_W'(1);
            done_ff[loaded_ff[IDX_W-1:0]] <= 1'b0;
         end
         if (cmd.do_update) begin
            if (tick_ff != '1) begin
               tick_ff <= tick_ff + TW'(1);
            end
            if (finishing) begin
               done_ff[best_idx_ff] <= 1'b1;
               completed_ff         <= completed_ff + CNT_W'(1);
            end
         end
      end
   end

   // scan address and read tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.scan_issue;
         if (cmd.tick_start) begin
            scan_idx_ff <= '0;
         end else if (cmd.scan_issue) begin
            scan_idx_ff <= scan_idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= scan_idx_ff;
   end

   // candidate test on the entry just read
   assign candidate = rd_valid_ff && !done_ff[rd_idx_ff]
                      && ({{(TW - ppsch_pkg::TIME_W){1'b0}}, rd_entry.arrival_time} <= tick_ff)
                      && (!sel_valid_ff || (rd_entry.priority_value < best_prio_ff));

   // best candidate registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_valid_ff <= 1'b0;
      end else if (cmd.tick_start) begin
         sel_valid_ff <= 1'b0;
      end else if (candidate) begin
         sel_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (candidate) begin
         best_idx_ff   <= rd_idx_ff;
         best_prio_ff  <= rd_entry.priority_value;
         best_arr_ff   <= rd_entry.arrival_time;
         best_burst_ff <= rd_entry.burst_time;
         best_rem_ff   <= rd_entry.remaining;
      end
   end

   // turnaround after the tick has advanced
   always_ff @(posedge clock) begin
      if (cmd.do_update) begin
         fin_ff <= finishing;
      end
      if (cmd.do_calc) begin
         tat_ff <= fin_ff
                   ? tick_ff - {{(TW - ppsch_pkg::TIME_W){1'b0}}, best_arr_ff}
                   : '0;
      end
   end

   // result fields
   assign id_wide    = sel_valid_ff ? (32'(best_idx_ff) + 32'd1) : 32'd0;
   assign running_id = id_wide[ppsch_pkg::ID_W-1:0];
   assign all_done   = (completed_ff == loaded_ff);
   always_comb begin
      if (fin_ff && (tat_ff >= {{(TW - ppsch_pkg::TIME_W){1'b0}}, best_burst_ff})) begin
         waiting = tat_ff - {{(TW - ppsch_pkg::TIME_W){1'b0}}, best_burst_ff};
      end else begin
         waiting = '0;
      end
   end

   // output register, freed by a transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.do_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_out) begin
         rsp_data_ff <= {1'b0, all_done, waiting, tat_ff, tick_ff, fin_ff, running_id};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // status
   assign sts.table_empty = (loaded_ff == '0);
   assign sts.scan_last   = (CNT_W'(scan_idx_ff) == (loaded_ff - CNT_W'(1)));
   assign sts.out_free    = !rsp_valid_ff || rsp_tready;

   // done flags and completion count agree
   a_done_count: assert property (@(posedge clock) disable iff (reset)
      $countones(done_ff) == int'(completed_ff))
      else $error("done flags disagree with completion count");

   // never more completions than loads
   a_completed_le_loaded: assert property (@(posedge clock) disable iff (reset)
      completed_ff <= loaded_ff)
      else $error("completion count above load count");

   // a selected entry is always a loaded one
   a_sel_loaded: assert property (@(posedge clock) disable iff (reset)
      sel_valid_ff |-> (CNT_W'(best_idx_ff) < loaded_ff))
      else $error("selected entry beyond the loaded table");

   // the tick counter never goes backward
   a_tick_monotonic: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (tick_ff >= $past(tick_ff)))
      else $error("tick counter went backward");

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// self-checking testbench for the preemptive priority scheduler
`timescale 1ns / 1ps

module testbench;

   localparam int TIME_W       = ppsch_pkg::TIME_W;
   localparam int PRIO_W       = ppsch_pkg::PRIO_W;
   localparam int TICK_W       = ppsch_pkg::TICK_W;
   localparam int ID_W         = ppsch_pkg::ID_W;
   localparam int REQ_DATA_W   = ppsch_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W   = ppsch_pkg::RSP_DATA_W;
   localparam int TABLE_DEPTH  = ppsch_pkg::DEFAULT_MAX_PROCESSES;
   localparam int ITEM_TARGET  = 1000;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AFTER   = 150;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 400000;

   typedef enum bit {
      OP_LOAD = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   // load fields as they sit in req_tdata, lowest bits last
   typedef struct packed {
      logic [PRIO_W-1:0] priority_value;
      logic [TIME_W-1:0] burst_time;
      logic [TIME_W-1:0] arrival_time;
   } load_fields_type;

   // one tick report as it sits in rsp_tdata, lowest bits last
   typedef struct packed {
      logic              all_done;
      logic [TICK_W-1:0] waiting;
      logic [TICK_W-1:0] turnaround;
      logic [TICK_W-1:0] finish_time;
      logic              finished;
      logic [ID_W-1:0]   running_id;
   } tick_report_type;

   // process table mirror and queue of expected tick reports
   class sched_scoreboard;
      logic [TIME_W-1:0] arrival_tbl [TABLE_DEPTH];
      logic [TIME_W-1:0] burst_tbl   [TABLE_DEPTH];
      logic [PRIO_W-1:0] prio_tbl    [TABLE_DEPTH];
      logic [TIME_W-1:0] remain_tbl  [TABLE_DEPTH];
      bit                done_tbl    [TABLE_DEPTH];
      int unsigned       loaded;
      int unsigned       completed;
      logic [TICK_W-1:0] tick_now;
      tick_report_type   report_q [$];
      int unsigned       faults;
      int unsigned       results_seen;

      function new();
         loaded = 0;
         completed = 0;
         tick_now = '0;
         faults = 0;
         results_seen = 0;
         foreach (done_tbl[i]) done_tbl[i] = 1'b0;
      endfunction

      function int pending();
         return report_q.size();
      endfunction

      function void note_fault(string msg);
         faults++;
         if (faults <= 10) $display("%0t: %s", $time, msg);
      endfunction

      function void compare_field(string field, logic [TICK_W-1:0] want,
                                  logic [TICK_W-1:0] got);
         if (got !== want)
            note_fault($sformatf("report %0d %s: expected %0d, got %0d",
                                 results_seen, field, want, got));
      endfunction

      // update the table for one accepted transfer, queue a report for a tick
      function void note_input(op_type op, load_fields_type f);
         int              chosen;
         logic [PRIO_W-1:0] best;
         tick_report_type rep;
         chosen = -1;
         best = '0;
         rep = '0;
         if (op == OP_LOAD) begin
            // a full table drops the load
            if (loaded < TABLE_DEPTH) begin
               arrival_tbl[loaded] = f.arrival_time;
               burst_tbl[loaded] = f.burst_time;
               prio_tbl[loaded] = f.priority_value;
               remain_tbl[loaded] = f.burst_time;
               done_tbl[loaded] = 1'b0;
               loaded++;
            end
         end else begin
            // smallest priority among arrived, unfinished entries; first wins ties
            for (int i = 0; i < loaded; i++) begin
               if (!done_tbl[i] && {16'd0, arrival_tbl[i]} <= tick_now) begin
                  if (chosen < 0 || prio_tbl[i] < best) begin
                     best = prio_tbl[i];
                     chosen = i;
                  end
               end
            end
            if (tick_now != '1) tick_now++;
            rep.finish_time = tick_now;
            if (chosen >= 0) begin
               rep.running_id = ID_W'(chosen + 1);
               if (remain_tbl[chosen] <= 16'd1) begin
                  remain_tbl[chosen] = '0;
                  done_tbl[chosen] = 1'b1;
                  completed++;
                  rep.finished = 1'b1;
                  rep.turnaround = tick_now - {16'd0, arrival_tbl[chosen]};
                  rep.waiting = (rep.turnaround >= {16'd0, burst_tbl[chosen]}) ?
                                rep.turnaround - {16'd0, burst_tbl[chosen]} : '0;
               end else begin
                  remain_tbl[chosen]--;
               end
            end
            rep.all_done = (completed == loaded);
            report_q = {report_q, rep};
         end
      endfunction

      // compare one result transfer with the oldest expected report
      function void check_result(logic [RSP_DATA_W-1:0] data);
         tick_report_type got;
         tick_report_type want;
         got = tick_report_type'(data[RSP_DATA_W-2:0]);
         results_seen++;
         if (report_q.size() == 0) begin
            note_fault($sformatf("report %0d arrived with none expected: %h",
                                 results_seen, data));
         end else begin
            want = report_q.pop_front();
            compare_field("running_id", TICK_W'(want.running_id), TICK_W'(got.running_id));
            compare_field("finished", TICK_W'(want.finished), TICK_W'(got.finished));
            compare_field("finish_time", want.finish_time, got.finish_time);
            compare_field("turnaround", want.turnaround, got.turnaround);
            compare_field("waiting", want.waiting, got.waiting);
            compare_field("all_done", TICK_W'(want.all_done), TICK_W'(got.all_done));
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [0:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   sched_scoreboard sb = new();
   bit              steady = 1'b0;
   int unsigned     ticks_sent = 0;
   int unsigned     loads_sent = 0;
   int unsigned     cycle_count = 0;

   preemptive_priority_scheduler u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // transfer monitors on both channels
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_input(op_type'(req_tuser), load_fields_type'(req_tdata));
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata);
   end

   // one item on the input channel, with random idle cycles ahead of it outside the steady window
   task automatic send_item(input op_type op, input load_fields_type f);
      while (!steady && $urandom_range(0, 99) < 37) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= f;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_TICK) ticks_sent++;
      else loads_sent++;
   endtask

   task automatic load_entry(input logic [TIME_W-1:0] arrival,
                             input logic [TIME_W-1:0] burst,
                             input logic [PRIO_W-1:0] prio);
      load_fields_type f;
      f.arrival_time = arrival;
      f.burst_time = burst;
      f.priority_value = prio;
      send_item(OP_LOAD, f);
   endtask

   // ignored fields of a tick carry random bits
   task automatic tick_once();
      send_item(OP_TICK, load_fields_type'(REQ_DATA_W'({$urandom(), $urandom()})));
   endtask

   // receiver: random stalls, one long hold-off, a calm window
   initial begin : rsp_side
      bit held;
      held = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held && sb.results_seen >= HOLD_AFTER) begin
            held = 1'b1;
            repeat (HOLD_CYCLES) begin
               rsp_tready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_tready <= steady || ($urandom_range(0, 99) >= 37);
      end
   end

   // stimulus and end of run
   initial begin : req_side
      int                items;
      int                roll;
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] burst;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser <= OP_LOAD;
      req_tdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty table: idle report with all done
      tick_once();
      load_entry(16'd0, 16'd3, 8'd255);
      tick_once();
      // urgent arrival preempts; zero burst ties and loses to the lower id
      load_entry(16'd2, 16'd1, 8'd0);
      load_entry(16'd2, 16'd0, 8'd0);
      // last ticks run idle after everything is done
      repeat (6) tick_once();
      // late load whose arrival has already passed
      load_entry(16'd0, 16'd1, 8'd7);
      repeat (2) tick_once();
      // entry that never arrives within the run
      load_entry(16'hFFFF, 16'hFFFF, 8'd128);
      tick_once();

      // random mix, mostly ticks, loads spread until the table is full
      items = 0;
      while (items < ITEM_TARGET) begin
         steady = (items >= 400 && items < 600);
         if (items == 700) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (sb.pending() != 0) @(posedge clock);
         end
         roll = $urandom_range(0, 99);
         if ($urandom_range(0, 7) == 0)
            arrival = TIME_W'($urandom_range(0, 65535));
         else
            arrival = TIME_W'(ticks_sent + $urandom_range(0, 24));
         if ($urandom_range(0, 9) == 0)
            burst = TIME_W'($urandom_range(1, 65535));
         else
            burst = TIME_W'($urandom_range(1, 12));
         if (loads_sent < TABLE_DEPTH && roll < 6) begin
            load_entry(arrival, burst, PRIO_W'($urandom_range(0, 255)));
            items++;
         end else if (loads_sent >= TABLE_DEPTH && roll < 3) begin
            // table full, the load is dropped
            load_entry(arrival, burst, PRIO_W'($urandom_range(0, 255)));
         end else begin
            tick_once();
            items++;
         end
      end
      steady = 1'b0;

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.faults == 0 && sb.pending() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ sim.f @@
design/ppsch_pkg.sv
design/ppsch_ram.sv
design/ppsch_ctrl.sv
design/ppsch_dp.sv
design/preemptive_priority_scheduler.sv
test/testbench.sv
